// ----- rtl/lae_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the life automaton engine.
// No dependencies; used by every module of the block.
package lae_pkg;

    localparam int ROWS    = 8;
    localparam int COLUMNS = 8;
    localparam int ROW_W   = $clog2(ROWS);

    // Field widths of the streamed items
    localparam int OP_W        = 2;
    localparam int CELL_ROW_W  = 3;
    localparam int CELL_COL_W  = 3;
    localparam int ROW_INDEX_W = 3;
    localparam int ROW_CELLS_W = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    localparam logic [OP_W-1:0] OP_SET     = 2'd0;
    localparam logic [OP_W-1:0] OP_EMIT    = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

    typedef logic [COLUMNS-1:0] row_t;

    // Commands from the sequencer to the grid store
    typedef struct packed {
        logic                  set_en;
        logic [ROW_W-1:0]      set_row;
        logic [CELL_COL_W-1:0] set_col;
        logic                  set_val;
        logic                  rotate_en;
        row_t                  rotate_in;
    } grid_ctrl_t;

endpackage

// ----- rtl/lae_row_unit.sv -----
`timescale 1ns / 1ps
// Shared next-generation unit: computes one new grid row from three old rows.
// Depends on lae_pkg.
module lae_row_unit (
    input  lae_pkg::row_t above,
    input  lae_pkg::row_t centre,
    input  lae_pkg::row_t below,
    output lae_pkg::row_t new_row
);

    // Zero padding at both ends stands for the dead cells beyond the edge
    logic [lae_pkg::COLUMNS+1:0] pad_a;
    logic [lae_pkg::COLUMNS+1:0] pad_c;
    logic [lae_pkg::COLUMNS+1:0] pad_b;

    assign pad_a = {1'b0, above,  1'b0};
    assign pad_c = {1'b0, centre, 1'b0};
    assign pad_b = {1'b0, below,  1'b0};

    always_comb begin
        logic [3:0] n;
        for (int c = 0; c < lae_pkg::COLUMNS; c++) begin
            n = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2])
              + 4'(pad_c[c])                  + 4'(pad_c[c+2])
              + 4'(pad_b[c]) + 4'(pad_b[c+1]) + 4'(pad_b[c+2]);
            new_row[c] = (n == 4'd3) || (pad_c[c+1] && (n == 4'd2));
        end
    end

endmodule

// ----- rtl/lae_grid.sv -----
`timescale 1ns / 1ps
// Cell grid store: rows held as a circular shift line, read at rows 0 and 1.
// Depends on lae_pkg.
module lae_grid (
    input  logic                aclk,
    input  logic                aresetn,
    input  lae_pkg::grid_ctrl_t ctrl,
    output lae_pkg::row_t       row0,
    output lae_pkg::row_t       row1
);

    lae_pkg::row_t grid_reg [lae_pkg::ROWS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < lae_pkg::ROWS; r++) begin
                grid_reg[r] <= '0;
            end
        end else if (ctrl.rotate_en) begin
            // Head row leaves, the replacement joins at the tail
            for (int r = 0; r < lae_pkg::ROWS - 1; r++) begin
                grid_reg[r] <= grid_reg[r+1];
            end
            grid_reg[lae_pkg::ROWS-1] <= ctrl.rotate_in;
        end else if (ctrl.set_en) begin
            grid_reg[ctrl.set_row][ctrl.set_col] <= ctrl.set_val;
        end
    end

    assign row0 = grid_reg[0];
    assign row1 = grid_reg[1];

endmodule

// ----- rtl/life_automaton_engine.sv -----
`timescale 1ns / 1ps
// Life automaton engine top level: sequencer, output register, grid, row unit.
// Depends on lae_pkg, lae_grid and lae_row_unit.
//
// Usage:
//   The s_ channel carries commands: set one cell, emit the grid, or advance
//   one generation (op code 3 is ignored). The m_ channel carries one transfer
//   per grid row on emit, row 0 first, with m_tlast on the final row.
//   A set is written into the grid at its transfer. An advance holds s_tready
//   low after its transfer while the single row unit produces one new row per
//   cycle as the grid rotates past it, until every row has been replaced.
//   An emit enters the emit state on its transfer, then loads row 0 into the
//   output register once that register is free, and holds s_tready low until
//   the last row is loaded; the grid rotates one row per row loaded, so
//   a receiver stall simply holds the sequencer.
//   s_tready is low while an advance or emit is running; a finished row may
//   wait in the output register while the next command is taken.
//   Out-of-range set coordinates are ignored.
//   Reset (aresetn low, synchronous) clears all cells to dead, empties the
//   output register and returns the sequencer to idle.
module life_automaton_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op[1:0], cell_row[4:2], cell_col[7:5], cell_value[8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // row_index[2:0], row_cells[10:3]
    output logic        m_tlast
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_ADVANCE = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    localparam logic [lae_pkg::ROW_W-1:0] LAST_ROW = lae_pkg::ROW_W'(lae_pkg::ROWS - 1);

    logic [1:0]                 state_reg, state_next;
    logic [lae_pkg::ROW_W-1:0]  cnt_reg, cnt_next;
    lae_pkg::row_t              above_reg, above_next;
    logic                       out_valid_reg, out_valid_next;
    logic [lae_pkg::ROW_INDEX_W-1:0] out_index_reg, out_index_next;
    logic [lae_pkg::ROW_CELLS_W-1:0] out_cells_reg, out_cells_next;
    logic                       out_last_reg, out_last_next;

    lae_pkg::grid_ctrl_t        ctrl;
    lae_pkg::row_t              row0, row1, below, new_row;

    logic [lae_pkg::OP_W-1:0]       in_op;
    logic [lae_pkg::CELL_ROW_W-1:0] in_row;
    logic [lae_pkg::CELL_COL_W-1:0] in_col;
    logic                           in_val;
    logic                           in_xfer;
    logic                           out_free;
    logic                           at_last;

    assign in_op  = s_tdata[1:0];
    assign in_row = s_tdata[4:2];
    assign in_col = s_tdata[7:5];
    assign in_val = s_tdata[8];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign at_last  = (cnt_reg == LAST_ROW);

    // Row below the last one lies outside the grid
    assign below = at_last ? '0 : row1;

    lae_row_unit u_row_unit (
        .above   (above_reg),
        .centre  (row0),
        .below   (below),
        .new_row (new_row)
    );

    lae_grid u_grid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .row0    (row0),
        .row1    (row1)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        above_next     = above_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_cells_next = out_cells_reg;
        out_last_next  = out_last_reg;

        ctrl           = '0;
        ctrl.set_row   = lae_pkg::ROW_W'(in_row);
        ctrl.set_col   = in_col;
        ctrl.set_val   = in_val;
        ctrl.rotate_in = row0;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                cnt_next   = '0;
                above_next = '0;
                if (in_xfer) begin
                    case (in_op)
                        lae_pkg::OP_SET: begin
                            ctrl.set_en = (int'(in_row) < lae_pkg::ROWS)
                                       && (int'(in_col) < lae_pkg::COLUMNS);
                        end
                        lae_pkg::OP_EMIT:    state_next = ST_EMIT;
                        lae_pkg::OP_ADVANCE: state_next = ST_ADVANCE;
                        default: ;
                    endcase
                end
            end
            ST_ADVANCE: begin
                ctrl.rotate_en = 1'b1;
                ctrl.rotate_in = new_row;
                above_next     = row0;
                cnt_next       = cnt_reg + 1'b1;
                if (at_last) begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ctrl.rotate_en = 1'b1;
                    out_valid_next = 1'b1;
                    out_index_next = lae_pkg::ROW_INDEX_W'(cnt_reg);
                    out_cells_next = lae_pkg::ROW_CELLS_W'(row0);
                    out_last_next  = at_last;
                    cnt_next       = cnt_reg + 1'b1;
                    if (at_last) begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        above_reg     <= above_next;
        out_index_reg <= out_index_next;
        out_cells_reg <= out_cells_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_cells_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // Final row of an emit run carries the last row index
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[2:0] == lae_pkg::ROW_INDEX_W'(lae_pkg::ROWS - 1))
        else $error("tlast on a row other than the last");

    // An advance command blocks the input on the next cycle
    a_adv_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[1:0] == lae_pkg::OP_ADVANCE) |=> !s_tready)
        else $error("input taken during advance");

    // A generation finishes after exactly one pass over the rows
    a_adv_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADVANCE) && at_last |=> (state_reg == ST_IDLE) && (cnt_reg == '0))
        else $error("advance pass did not end cleanly");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the life automaton engine: random stream traffic with
// back-pressure, checked against a cycle-free grid predictor. Uses lae_pkg.
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 340;
    localparam logic [lae_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef logic [lae_pkg::ROWS-1:0][lae_pkg::COLUMNS-1:0] board_t;

    typedef struct packed {
        logic [lae_pkg::ROW_INDEX_W-1:0] row_index;
        lae_pkg::row_t                   row_cells;
        logic                            last;
    } row_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [lae_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [lae_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    logic [lae_pkg::S_TDATA_W-1:0] cmd_q[$];
    row_result_t          row_expect_q[$];
    board_t               life_grid = '0;
    logic                 in_fire = 1'b0;
    int                   in_gap = 0;
    int                   out_stall = 0;
    bit                   in_quiet = 1'b0;
    bit                   out_quiet = 1'b0;
    int                   err_count = 0;
    int                   cycle_count = 0;
    int                   counted_items = 0;

    life_automaton_engine uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
    end

    // One generation; cells beyond the edge count as dead
    function automatic board_t next_generation(input board_t g);
        board_t nxt;
        int     n;
        int     rr;
        int     cc;
        nxt = '0;
        for (int r = 0; r < lae_pkg::ROWS; r++) begin
            for (int c = 0; c < lae_pkg::COLUMNS; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < lae_pkg::ROWS
                            && cc >= 0 && cc < lae_pkg::COLUMNS)
                            n += g[rr][cc];
                    end
                end
                nxt[r][c] = g[r][c] ? (n == 2 || n == 3) : (n == 3);
            end
        end
        return nxt;
    endfunction

    task automatic apply_cmd(input logic [lae_pkg::S_TDATA_W-1:0] d);
        logic [lae_pkg::OP_W-1:0] op;
        int              r;
        int              c;
        row_result_t     e;
        op = d[1:0];
        r  = int'(d[4:2]);
        c  = int'(d[7:5]);
        case (op)
            lae_pkg::OP_SET: begin
                if (r < lae_pkg::ROWS && c < lae_pkg::COLUMNS)
                    life_grid[r][c] = d[8];
            end
            lae_pkg::OP_EMIT: begin
                for (int k = 0; k < lae_pkg::ROWS; k++) begin
                    e.row_index = k[lae_pkg::ROW_INDEX_W-1:0];
                    e.row_cells = life_grid[k];
                    e.last      = (k == lae_pkg::ROWS - 1);
                    row_expect_q.push_back(e);
                end
            end
            lae_pkg::OP_ADVANCE: life_grid = next_generation(life_grid);
            default: ;
        endcase
    endtask

    task automatic check_row(input logic [lae_pkg::M_TDATA_W-1:0] d, input logic lst);
        row_result_t got;
        row_result_t e;
        got.row_index = d[2:0];
        got.row_cells = d[10:3];
        got.last      = lst;
        if (row_expect_q.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("unexpected row transfer: index %0d cells %b last %b",
                         got.row_index, got.row_cells, got.last);
        end else begin
            e = row_expect_q.pop_front();
            if (got !== e) begin
                err_count++;
                if (err_count <= 10)
                    $display({"row mismatch: expected index %0d cells %b last %b, ",
                              "got index %0d cells %b last %b"},
                             e.row_index, e.row_cells, e.last,
                             got.row_index, got.row_cells, got.last);
            end
        end
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic queue_cmd(input logic [lae_pkg::OP_W-1:0] op, input int r, input int c,
                             input bit v);
        logic [lae_pkg::CELL_ROW_W-1:0] rb;
        logic [lae_pkg::CELL_COL_W-1:0] cb;
        rb = r[lae_pkg::CELL_ROW_W-1:0];
        cb = c[lae_pkg::CELL_COL_W-1:0];
        cmd_q.push_back({{(lae_pkg::S_TDATA_W-9){1'b0}}, v, cb, rb, op});
        if (op != OP_UNUSED)
            counted_items++;
    endtask

    task automatic queue_noise();
        queue_cmd(lae_pkg::OP_W'($urandom_range(0, 3)), $urandom_range(0, 7),
                  $urandom_range(0, 7), 1'($urandom_range(0, 1)));
    endtask

    // Ignored fields of emit/advance carry random bits too
    task automatic queue_op(input logic [lae_pkg::OP_W-1:0] op);
        queue_cmd(op, $urandom_range(0, 7), $urandom_range(0, 7), 1'($urandom_range(0, 1)));
    endtask

    // Predictor and result checks at the rising edge; check before the new transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
                check_row(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                apply_cmd(s_tdata);
        end
    end

    // Input driver: holds an item until its transfer, then an optional gap
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_fire) begin
            // waiting for s_tready
        end else if (in_gap > 0) begin
            s_tvalid <= 1'b0;
            in_gap   <= in_gap - 1;
        end else if (cmd_q.size() > 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= cmd_q.pop_front();
            if ($urandom_range(0, 49) == 0)
                in_quiet <= !in_quiet;
            if (!in_quiet && $urandom_range(0, 2) == 0)
                in_gap <= gap_len();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        if ($urandom_range(0, 99) == 0)
            out_quiet <= !out_quiet;
        if (out_stall > 0) begin
            m_tready  <= 1'b0;
            out_stall <= out_stall - 1;
        end else if (!out_quiet && $urandom_range(0, 4) == 0) begin
            m_tready  <= 1'b0;
            out_stall <= gap_len() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int kind;
        int n;

        // Corners, clearing a cell, the unused op, lone cells dying out
        queue_cmd(lae_pkg::OP_SET, 0, 0, 1'b1);
        queue_cmd(lae_pkg::OP_SET, 7, 7, 1'b1);
        queue_cmd(lae_pkg::OP_SET, 0, 7, 1'b1);
        queue_cmd(lae_pkg::OP_SET, 7, 0, 1'b1);
        queue_op(lae_pkg::OP_EMIT);
        queue_cmd(lae_pkg::OP_SET, 0, 0, 1'b0);
        queue_cmd(OP_UNUSED, 7, 7, 1'b1);
        queue_op(lae_pkg::OP_EMIT);
        queue_op(lae_pkg::OP_ADVANCE);
        queue_op(lae_pkg::OP_EMIT);
        // blinker in the middle, block pinned in a corner
        queue_cmd(lae_pkg::OP_SET, 3, 2, 1'b1);
        queue_cmd(lae_pkg::OP_SET, 3, 3, 1'b1);
        queue_cmd(lae_pkg::OP_SET, 3, 4, 1'b1);
        queue_cmd(lae_pkg::OP_SET, 6, 6, 1'b1);
        queue_cmd(lae_pkg::OP_SET, 6, 7, 1'b1);
        queue_cmd(lae_pkg::OP_SET, 7, 6, 1'b1);
        queue_cmd(lae_pkg::OP_SET, 7, 7, 1'b1);
        queue_op(lae_pkg::OP_EMIT);
        queue_op(lae_pkg::OP_ADVANCE);
        queue_op(lae_pkg::OP_EMIT);
        queue_op(lae_pkg::OP_ADVANCE);
        queue_op(lae_pkg::OP_EMIT);
        queue_cmd(OP_UNUSED, 0, 0, 1'b0);

        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                // seed a pattern, then let it evolve
                n = $urandom_range(6, 20);
                repeat (n)
                    queue_cmd(lae_pkg::OP_SET, $urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom_range(0, 3) != 0);
                n = $urandom_range(2, 6);
                repeat (n) begin
                    queue_op(lae_pkg::OP_ADVANCE);
                    if ($urandom_range(0, 2) != 0)
                        queue_op(lae_pkg::OP_EMIT);
                    if ($urandom_range(0, 9) == 0)
                        queue_noise();
                end
                queue_op(lae_pkg::OP_EMIT);
            end else if (kind <= 7) begin
                n = $urandom_range(6, 12);
                repeat (n)
                    queue_noise();
            end else if (kind == 8) begin
                repeat (6) begin
                    queue_op(lae_pkg::OP_ADVANCE);
                    queue_op(lae_pkg::OP_EMIT);
                end
            end else begin
                // emits back to back
                n = $urandom_range(3, 5);
                repeat (n)
                    queue_op(lae_pkg::OP_EMIT);
            end
        end

        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        while (cmd_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (row_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (row_expect_q.size() != 0)
            $display("rows still outstanding: %0d", row_expect_q.size());
        if (err_count == 0 && row_expect_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lae_pkg.sv
rtl/lae_row_unit.sv
rtl/lae_grid.sv
rtl/life_automaton_engine.sv
tb/testbench.sv
